// ===== src/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg : shared types and constants for the quaternion vector rotator
// Fixed-point widths of both product stages, register map, rounding helpers.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int Q_W      = 16;              // quaternion component, Q1.14
    localparam int V_W      = 32;              // vector component, Q16.16
    localparam int FRAC     = 14;              // fraction bits dropped per stage

    localparam int P1_W     = Q_W + V_W;       // q * v product
    localparam int S1_W     = P1_W + 1;        // sum of three products
    localparam int T_W      = S1_W - FRAC;     // rounded t component
    localparam int P2_W     = T_W + Q_W;       // t * q product
    localparam int S2_W     = P2_W + 2;        // sum of four products
    localparam int R_W      = S2_W - FRAC;     // rounded r component, pre-saturation

    localparam int N_P1     = 12;
    localparam int N_P2     = 12;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUAT_W = 2'd0,
        CFG_QUAT_X = 2'd1,
        CFG_QUAT_Y = 2'd2,
        CFG_QUAT_Z = 2'd3
    } cfg_index_t;

    localparam logic signed [Q_W-1:0] QUAT_W_RESET = 16'sd16384;

    // round to nearest, ties up: add half an lsb then floor-shift
    function automatic logic signed [T_W-1:0] round_s1(input logic signed [S1_W-1:0] sum);
        logic signed [S1_W-1:0] biased;
        biased = sum + S1_W'(1 << (FRAC - 1));
        return signed'(biased[S1_W-1:FRAC]);
    endfunction

    function automatic logic signed [R_W-1:0] round_s2(input logic signed [S2_W-1:0] sum);
        logic signed [S2_W-1:0] biased;
        biased = sum + S2_W'(1 << (FRAC - 1));
        return signed'(biased[S2_W-1:FRAC]);
    endfunction

endpackage

// ===== src/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate : rotate Q16.16 vectors by a Q1.14 quaternion
// Computes q * v * conj(q) in a four-stage pipeline, saturating the result.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | sink      | in_valid / in_stall | vec_x, vec_y, vec_z
//  out     | source    | out_valid/out_stall | rot_x, rot_y, rot_z, saturated
//  cfg     | sink      | cfg_wr_en           | cfg_index, cfg_data
//
//  One beat per cycle sustained while out_stall is low; an accepted beat passes
//  the four register stages (products of q*v, rounded t, products of t*conj(q),
//  rounded and saturated r) before it is offered on the output.
//  Reset clears the stage valid bits and loads the identity quaternion.
//  A stall holds each full stage with only full stages after it; empty stages
//  keep filling, so bubbles are squeezed out and nothing is dropped or repeated.
//
module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [V_W-1:0] vec_x,
    input  logic signed [V_W-1:0] vec_y,
    input  logic signed [V_W-1:0] vec_z,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [V_W-1:0] rot_x,
    output logic signed [V_W-1:0] rot_y,
    output logic signed [V_W-1:0] rot_z,
    output logic                 saturated,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [Q_W-1:0]       cfg_data
);

    // ------------------------------------------------------------------
    // Quaternion registers. Only to be written by the user while the pipe is
    // empty, so the stages read them live; the block itself does not enforce this.
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0] qw_reg, qx_reg, qy_reg, qz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qw_reg <= QUAT_W_RESET;
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_QUAT_W: qw_reg <= signed'(cfg_data);
                CFG_QUAT_X: qx_reg <= signed'(cfg_data);
                CFG_QUAT_Y: qy_reg <= signed'(cfg_data);
                CFG_QUAT_Z: qz_reg <= signed'(cfg_data);
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and advance chain. A stage moves when it is empty
    // or the one after it moves.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4     = !v4_reg || !out_stall;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the twelve q * v products.
    //   tw = -qx*vx - qy*vy - qz*vz   (0..2)
    //   tx =  qw*vx + qy*vz - qz*vy   (3..5)
    //   ty =  qw*vy + qz*vx - qx*vz   (6..8)
    //   tz =  qw*vz + qx*vy - qy*vx   (9..11)
    // ------------------------------------------------------------------
    logic signed [P1_W-1:0] p1_reg  [N_P1];
    logic signed [P1_W-1:0] p1_next [N_P1];

    always_comb
    begin
        p1_next[0]  = P1_W'(qx_reg) * P1_W'(vec_x);
        p1_next[1]  = P1_W'(qy_reg) * P1_W'(vec_y);
        p1_next[2]  = P1_W'(qz_reg) * P1_W'(vec_z);
        p1_next[3]  = P1_W'(qw_reg) * P1_W'(vec_x);
        p1_next[4]  = P1_W'(qy_reg) * P1_W'(vec_z);
        p1_next[5]  = P1_W'(qz_reg) * P1_W'(vec_y);
        p1_next[6]  = P1_W'(qw_reg) * P1_W'(vec_y);
        p1_next[7]  = P1_W'(qz_reg) * P1_W'(vec_x);
        p1_next[8]  = P1_W'(qx_reg) * P1_W'(vec_z);
        p1_next[9]  = P1_W'(qw_reg) * P1_W'(vec_z);
        p1_next[10] = P1_W'(qx_reg) * P1_W'(vec_y);
        p1_next[11] = P1_W'(qy_reg) * P1_W'(vec_x);
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
            p1_reg <= p1_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: sum and round t; no saturation, range fits T_W.
    // ------------------------------------------------------------------
    logic signed [T_W-1:0] tw_reg, tx_reg, ty_reg, tz_reg;
    logic signed [S1_W-1:0] sw_sum, sx_sum, sy_sum, sz_sum;

    always_comb
    begin
        sw_sum = -S1_W'(p1_reg[0]) - S1_W'(p1_reg[1])  - S1_W'(p1_reg[2]);
        sx_sum =  S1_W'(p1_reg[3]) + S1_W'(p1_reg[4])  - S1_W'(p1_reg[5]);
        sy_sum =  S1_W'(p1_reg[6]) + S1_W'(p1_reg[7])  - S1_W'(p1_reg[8]);
        sz_sum =  S1_W'(p1_reg[9]) + S1_W'(p1_reg[10]) - S1_W'(p1_reg[11]);
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            tw_reg <= round_s1(sw_sum);
            tx_reg <= round_s1(sx_sum);
            ty_reg <= round_s1(sy_sum);
            tz_reg <= round_s1(sz_sum);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: t * conj(q) products.
    //   rx = tx*qw - tw*qx - ty*qz + tz*qy   (0..3)
    //   ry = ty*qw - tw*qy - tz*qx + tx*qz   (4..7)
    //   rz = tz*qw - tw*qz - tx*qy + ty*qx   (8..11)
    // ------------------------------------------------------------------
    logic signed [P2_W-1:0] p2_reg  [N_P2];
    logic signed [P2_W-1:0] p2_next [N_P2];

    always_comb
    begin
        p2_next[0]  = P2_W'(tx_reg) * P2_W'(qw_reg);
        p2_next[1]  = P2_W'(tw_reg) * P2_W'(qx_reg);
        p2_next[2]  = P2_W'(ty_reg) * P2_W'(qz_reg);
        p2_next[3]  = P2_W'(tz_reg) * P2_W'(qy_reg);
        p2_next[4]  = P2_W'(ty_reg) * P2_W'(qw_reg);
        p2_next[5]  = P2_W'(tw_reg) * P2_W'(qy_reg);
        p2_next[6]  = P2_W'(tz_reg) * P2_W'(qx_reg);
        p2_next[7]  = P2_W'(tx_reg) * P2_W'(qz_reg);
        p2_next[8]  = P2_W'(tz_reg) * P2_W'(qw_reg);
        p2_next[9]  = P2_W'(tw_reg) * P2_W'(qz_reg);
        p2_next[10] = P2_W'(tx_reg) * P2_W'(qy_reg);
        p2_next[11] = P2_W'(ty_reg) * P2_W'(qx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
            p2_reg <= p2_next;
    end

    // ------------------------------------------------------------------
    // Stage 4: sum, round, clip to Q16.16 and flag any clipped lane.
    // ------------------------------------------------------------------
    localparam logic signed [R_W-1:0] OUT_MAX = R_W'({1'b0, {(V_W-1){1'b1}}});
    localparam logic signed [R_W-1:0] OUT_MIN = -OUT_MAX - R_W'(1);

    logic signed [S2_W-1:0] rx_sum, ry_sum, rz_sum;
    logic signed [R_W-1:0]  rx_rnd, ry_rnd, rz_rnd;
    logic [2:0]             hi_clip, lo_clip;

    logic signed [V_W-1:0] rot_x_next, rot_y_next, rot_z_next;
    logic signed [V_W-1:0] rot_x_reg, rot_y_reg, rot_z_reg;
    logic                  sat_reg;

    always_comb
    begin
        rx_sum = S2_W'(p2_reg[0]) - S2_W'(p2_reg[1]) - S2_W'(p2_reg[2])  + S2_W'(p2_reg[3]);
        ry_sum = S2_W'(p2_reg[4]) - S2_W'(p2_reg[5]) - S2_W'(p2_reg[6])  + S2_W'(p2_reg[7]);
        rz_sum = S2_W'(p2_reg[8]) - S2_W'(p2_reg[9]) - S2_W'(p2_reg[10]) + S2_W'(p2_reg[11]);

        rx_rnd = round_s2(rx_sum);
        ry_rnd = round_s2(ry_sum);
        rz_rnd = round_s2(rz_sum);

        hi_clip = {rz_rnd > OUT_MAX, ry_rnd > OUT_MAX, rx_rnd > OUT_MAX};
        lo_clip = {rz_rnd < OUT_MIN, ry_rnd < OUT_MIN, rx_rnd < OUT_MIN};

        rot_x_next = hi_clip[0] ? OUT_MAX[V_W-1:0] :
                     lo_clip[0] ? OUT_MIN[V_W-1:0] : rx_rnd[V_W-1:0];
        rot_y_next = hi_clip[1] ? OUT_MAX[V_W-1:0] :
                     lo_clip[1] ? OUT_MIN[V_W-1:0] : ry_rnd[V_W-1:0];
        rot_z_next = hi_clip[2] ? OUT_MAX[V_W-1:0] :
                     lo_clip[2] ? OUT_MIN[V_W-1:0] : rz_rnd[V_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            rot_x_reg <= rot_x_next;
            rot_y_reg <= rot_y_next;
            rot_z_reg <= rot_z_next;
            sat_reg   <= |(hi_clip | lo_clip);
        end
    end

    assign out_valid = v4_reg;
    assign rot_x     = rot_x_reg;
    assign rot_y     = rot_y_reg;
    assign rot_z     = rot_z_reg;
    assign saturated = sat_reg;

endmodule
